// ----- hw/rtl/kbce_pkg.sv -----
// Package: shared types, constants and codes of the keyframe Bezier evaluator.
`timescale 1ns / 1ps
`default_nettype none
package kbce_pkg;

  localparam int MaxKeys  = 16;
  localparam int FracBits = 12;
  localparam int IdxW     = $clog2(MaxKeys);
  localparam int CntW     = $clog2(MaxKeys + 1);
  localparam int UW       = FracBits + 1;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_EVAL   = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_DUP    = 3'd1;
  localparam logic [2:0] ST_FULL   = 3'd2;
  localparam logic [2:0] ST_BADIDX = 3'd3;
  localparam logic [2:0] ST_NOSEG  = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] time_point;
    logic signed [15:0] key_value;
    logic signed [15:0] out_ctrl_y;
    logic signed [15:0] in_ctrl_y;
    logic [3:0]         remove_index;
  } kbce_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         key_index;
    logic signed [15:0] curve_value;
  } kbce_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_DIV, S_MUL, S_DONE
  } kbce_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/keyframe_bezier_curve_evaluator_core.sv -----
// Top level: key table, scan sequencer, shared multiplier and result register.
//
// Usage: requests enter on in_valid/in_data/in_stall, one result per request
// leaves on out_valid/out_data/out_stall. One request is worked at a time;
// in_stall is high from acceptance until the result is taken.
// Add scans the keys for a duplicate, one key read a cycle, then posts the
// result. Remove shifts the entries above the index down, one a cycle.
// Evaluate scans for the bracketing keys, then runs the divider and 12
// multiplier steps; a match or missing bracket ends after the scan.
// The next request is accepted in the cycle after the result is taken.
// The scan visits one key a cycle through the table read port; the divider
// resolves one quotient bit a cycle; one 26x17 multiplier does every product.
// Reset clears the key count and the sequencer; table contents are not cleared.
// A result held under out_stall keeps the block busy and stalls input.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_bezier_curve_evaluator_core
  import kbce_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire kbce_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output kbce_out_t      out_data
);
  // Key table: four 16-bit fields per entry.
  logic [63:0] tbl [MaxKeys];
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] ptr_r, ptr_nxt;

  kbce_state_t st_r, st_nxt;
  kbce_in_t    req_r;
  logic        out_valid_r, out_valid_nxt;
  kbce_out_t   res_r, res_nxt;

  logic            has_lo_r, has_lo_nxt;
  logic [IdxW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [63:0]     lo_ent_r, hi_ent_r;

  logic [63:0] rd;
  logic signed [15:0] rt;
  assign rd = tbl[ptr_r[IdxW-1:0]];
  assign rt = rd[63:48];

  // Table write: append or shift down.
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [63:0]     wr_data;
  always_ff @(posedge clk) begin
    if (wr_en) tbl[wr_addr] <= wr_data;
  end

  // Divider
  logic        div_start, div_done;
  logic [16:0] div_num, div_den;
  logic [UW-1:0] u_q;
  kbce_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(div_den), .done(div_done), .quot(u_q)
  );
  logic signed [16:0] tq;
  assign tq      = 17'(signed'(req_r.time_point));
  assign div_num = 17'(tq - 17'(signed'(lo_ent_r[63:48])));
  assign div_den = 17'(17'(signed'(hi_ent_r[63:48])) - 17'(signed'(lo_ent_r[63:48])));

  // Multiply sequence; products are floor(a*b >> FracBits).
  logic signed [UW:0]  u_r, s_r, ss_r, su_r, tmp_r;
  logic signed [UW+2:0] b_r;
  logic signed [35:0]  acc_r, acc_nxt;
  logic [3:0]          mstep_r, mstep_nxt;
  logic signed [25:0]  ma;
  logic signed [16:0]  mb;
  logic signed [42:0]  mp;
  logic signed [30:0]  mq;
  assign mp = ma * mb;
  assign mq = 31'(mp >>> FracBits);

  always_comb begin
    ma = '0; mb = '0;
    unique case (mstep_r)
      4'd0:  begin ma = 26'(s_r);  mb = 17'(s_r); end
      4'd1:  begin ma = 26'(s_r);  mb = 17'(u_r); end
      4'd2:  begin ma = 26'(ss_r); mb = 17'(s_r); end
      4'd3:  begin ma = 26'(b_r);  mb = 17'(signed'(lo_ent_r[47:32])); end
      4'd4:  begin ma = 26'(ss_r); mb = 17'(u_r); end
      4'd5:  begin ma = 26'(b_r);  mb = 17'(signed'(lo_ent_r[31:16])); end
      4'd6:  begin ma = 26'(su_r); mb = 17'(u_r); end
      4'd7:  begin ma = 26'(b_r);  mb = 17'(signed'(hi_ent_r[15:0])); end
      4'd8:  begin ma = 26'(u_r);  mb = 17'(u_r); end
      4'd9:  begin ma = 26'(tmp_r); mb = 17'(u_r); end
      4'd10: begin ma = 26'(b_r);  mb = 17'(signed'(hi_ent_r[47:32])); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_DIV && div_done) begin
      u_r <= (UW+1)'(u_q);
      s_r <= (UW+1)'(1 << FracBits) - (UW+1)'(u_q);
    end
    if (st_r == S_MUL) begin
      unique case (mstep_r)
        4'd0: ss_r <= (UW+1)'(mq);
        4'd1: su_r <= (UW+1)'(mq);
        4'd2: b_r  <= (UW+3)'(mq);
        4'd4: b_r  <= (UW+3)'(mq * 3);
        4'd6: b_r  <= (UW+3)'(mq * 3);
        4'd8: tmp_r <= (UW+1)'(mq);
        4'd9: b_r  <= (UW+3)'(mq);
        default: ;
      endcase
    end
  end

  // Result saturation.
  logic signed [15:0] sat_y;
  always_comb begin
    if (acc_r > 36'sd32767)       sat_y = 16'sh7fff;
    else if (acc_r < -36'sd32768) sat_y = 16'sh8000;
    else                          sat_y = 16'(acc_r);
  end

  // Sequencer
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; ptr_nxt = ptr_r;
    out_valid_nxt = out_valid_r && out_stall;
    res_nxt = res_r;
    has_lo_nxt = has_lo_r; lo_nxt = lo_r; hi_nxt = hi_r;
    wr_en = 1'b0; wr_addr = ptr_r[IdxW-1:0]; wr_data = rd;
    mstep_nxt = mstep_r; acc_nxt = acc_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          ptr_nxt = '0; has_lo_nxt = 1'b0; mstep_nxt = '0; acc_nxt = '0;
          res_nxt = '0;
          case (in_data.req_type)
            REQ_ADD, REQ_EVAL: st_nxt = S_SCAN;
            REQ_REMOVE: begin
              if (CntW'(in_data.remove_index) >= cnt_r) begin
                res_nxt.status = ST_BADIDX; st_nxt = S_DONE;
              end else begin
                ptr_nxt = CntW'(in_data.remove_index) + 1'b1; st_nxt = S_SHIFT;
              end
            end
            default: begin res_nxt.status = ST_BADIDX; st_nxt = S_DONE; end
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_r >= cnt_r) begin
          if (req_r.req_type == REQ_ADD) begin
            if (cnt_r == CntW'(MaxKeys)) res_nxt.status = ST_FULL;
            else begin
              wr_en = 1'b1; wr_addr = cnt_r[IdxW-1:0];
              wr_data = {req_r.time_point, req_r.key_value,
                         req_r.out_ctrl_y, req_r.in_ctrl_y};
              res_nxt.key_index = 4'(cnt_r);
              cnt_nxt = cnt_r + 1'b1;
            end
            st_nxt = S_DONE;
          end else begin
            res_nxt.status = ST_NOSEG;
            res_nxt.curve_value = 16'(-(1 << FracBits));
            st_nxt = S_DONE;
          end
        end else if (rt == req_r.time_point) begin
          if (req_r.req_type == REQ_ADD) res_nxt.status = ST_DUP;
          else res_nxt.curve_value = rd[47:32];
          st_nxt = S_DONE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          if (req_r.req_type == REQ_EVAL) begin
            if (rt < req_r.time_point) begin
              has_lo_nxt = 1'b1; lo_nxt = ptr_r[IdxW-1:0];
            end else if (!has_lo_r) begin
              res_nxt.status = ST_NOSEG;
              res_nxt.curve_value = 16'(-(1 << FracBits));
              st_nxt = S_DONE;
            end else begin
              hi_nxt = ptr_r[IdxW-1:0];
              st_nxt = S_DIV;
            end
          end
        end
      end
      S_SHIFT: begin
        if (ptr_r >= cnt_r) begin
          cnt_nxt = cnt_r - 1'b1; st_nxt = S_DONE;
        end else begin
          wr_en = 1'b1; wr_addr = IdxW'(ptr_r - 1'b1); wr_data = rd;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) st_nxt = S_MUL;
      end
      S_MUL: begin
        mstep_nxt = mstep_r + 1'b1;
        if (mstep_r == 4'd3 || mstep_r == 4'd5 || mstep_r == 4'd7 ||
            mstep_r == 4'd10)
          acc_nxt = acc_r + 36'(mq);
        if (mstep_r == 4'd11) begin
          res_nxt.curve_value = sat_y; st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Divider kick is registered; it rises on the edge that latches the bracketing keys.
  logic div_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) div_go_r <= 1'b0;
    else        div_go_r <= (st_r == S_SCAN) && (st_nxt == S_DIV);
  end
  logic kick;
  assign kick      = div_go_r;
  assign div_start = kick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt; res_r <= res_nxt; has_lo_r <= has_lo_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; mstep_r <= mstep_nxt; acc_r <= acc_nxt;
    if (in_valid && !in_stall) req_r <= in_data;
    if (st_r == S_SCAN && st_nxt == S_DIV) begin
      lo_ent_r <= tbl[lo_nxt];
      hi_ent_r <= rd;
    end
  end

  assign in_stall  = (st_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // Never hold more keys than the table.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxKeys)) else $error("key count overflow");
  // Multiply only with a lower key in hand.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MUL) |-> has_lo_r) else $error("multiply without lower key");
  // Count changes only on the cycle that completes add or remove.
  a_cnt_chg: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (st_r == S_DONE)) else $error("count changed mid-request");
  // Kick the divider only in the divide state.
  a_div_kick: assert property (@(posedge clk) disable iff (!rst_n)
    kick |-> st_r == S_DIV) else $error("divider kicked outside divide state");
  // Result stays while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(res_r)))
    else $error("result changed under stall");
endmodule
`default_nettype wire

// ----- hw/rtl/kbce_divider.sv -----
// Restoring divider: one quotient bit per cycle, quotient below one in Q format.
`timescale 1ns / 1ps
`default_nettype none
module kbce_divider
  import kbce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [16:0] num,
  input  wire logic [16:0] den,
  output logic             done,
  output logic [UW-1:0]    quot
);
  localparam int StepW = $clog2(FracBits + 1);

  logic [16:0]      rem_r, rem_nxt;
  logic [16:0]      den_r;
  logic [UW-1:0]    quot_r, quot_nxt;
  logic [StepW-1:0] step_r;
  logic             busy_r;
  logic [17:0]      trial;

  // Shift remainder, try subtract.
  always_comb begin
    trial    = {rem_r, 1'b0};
    rem_nxt  = trial[16:0];
    quot_nxt = {quot_r[UW-2:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt  = 17'(trial - {1'b0, den_r});
      quot_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == StepW'(FracBits - 1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign done = busy_r && (step_r == StepW'(FracBits - 1));
  assign quot = quot_nxt;
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the keyframe Bezier curve evaluator core with a self-checking scoreboard.
`timescale 1ns / 1ps
module testbench;
  import kbce_pkg::*;

  // Predictor of the key table and the expected responses
  class curve_scoreboard;
    int key_t[MaxKeys];
    int key_v[MaxKeys];
    int key_o[MaxKeys];
    int key_i[MaxKeys];
    int count;
    kbce_out_t pending[$];
    int mismatches;
    int checked;

    function new();
      count = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    // Floor of a*b / ONE
    function longint fmul(longint a, longint b);
      longint p;
      p = a * b;
      return p >>> FracBits;
    endfunction

    function void evaluate(int t, output logic [2:0] st, output longint val);
      bit has_lo, has_hi;
      int lo, hi, k;
      longint u, s, ss, su, y, one;
      has_lo = 0;
      has_hi = 0;
      lo = 0;
      hi = 0;
      one = longint'(1) << FracBits;
      for (k = 0; k < count; k++) begin
        if (key_t[k] == t) begin
          st = ST_OK;
          val = key_v[k];
          return;
        end
        if (key_t[k] < t) begin
          lo = k;
          has_lo = 1;
        end
        if (key_t[k] > t) begin
          hi = k;
          has_hi = 1;
          break;
        end
      end
      if (!has_lo || !has_hi) begin
        st = ST_NOSEG;
        val = -one;
        return;
      end
      u = ((longint'(t) - key_t[lo]) <<< FracBits) / (longint'(key_t[hi]) - key_t[lo]);
      s = one - u;
      ss = fmul(s, s);
      su = fmul(s, u);
      y = fmul(fmul(ss, s), key_v[lo]) + fmul(3 * fmul(ss, u), key_o[lo])
        + fmul(3 * fmul(su, u), key_i[hi]) + fmul(fmul(fmul(u, u), u), key_v[hi]);
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      st = ST_OK;
      val = y;
    endfunction

    // Apply an accepted request to the model and queue its response
    function void note_request(kbce_in_t rq);
      kbce_out_t r;
      bit dup;
      int k;
      longint val;
      logic [2:0] st;
      r = '0;
      case (rq.req_type)
        REQ_ADD: begin
          dup = 0;
          for (k = 0; k < count; k++) if (key_t[k] == rq.time_point) dup = 1;
          if (dup) r.status = ST_DUP;
          else if (count >= MaxKeys) r.status = ST_FULL;
          else begin
            key_t[count] = rq.time_point;
            key_v[count] = rq.key_value;
            key_o[count] = rq.out_ctrl_y;
            key_i[count] = rq.in_ctrl_y;
            r.key_index = count[3:0];
            count++;
          end
        end
        REQ_REMOVE: begin
          if (rq.remove_index >= count) r.status = ST_BADIDX;
          else begin
            for (k = rq.remove_index; k + 1 < count; k++) begin
              key_t[k] = key_t[k+1];
              key_v[k] = key_v[k+1];
              key_o[k] = key_o[k+1];
              key_i[k] = key_i[k+1];
            end
            count--;
          end
        end
        REQ_EVAL: begin
          evaluate(rq.time_point, st, val);
          r.status = st;
          r.curve_value = val[15:0];
        end
        default: r.status = ST_BADIDX;
      endcase
      pending.insert(pending.size(), r);
    endfunction

    // Compare a response with the oldest expectation
    function void check_response(kbce_out_t got);
      kbce_out_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status || got.key_index !== exp_r.key_index ||
          got.curve_value !== exp_r.curve_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d idx=%0d val=%0d got st=%0d idx=%0d val=%0d",
                   exp_r.status, exp_r.key_index, exp_r.curve_value,
                   got.status, got.key_index, got.curve_value);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  kbce_in_t in_data;
  logic out_valid;
  logic out_stall;
  kbce_out_t out_data;

  curve_scoreboard sb;
  int idle_cycles;
  bit calm;
  int n_add, n_rem, n_eval;
  int pool_t[8];

  keyframe_bezier_curve_evaluator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Note accepted requests, check responses, watch for a hang
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_response(out_data);
    if (rst_n && !(in_valid && !in_stall) && !(out_valid && !out_stall)) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles > 5000) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Random response-side stall bursts
  initial begin
    int k, n;
    out_stall = 0;
    forever begin
      n = $urandom_range(1, 14);
      if (!calm && $urandom_range(0, 2) == 0) begin
        for (k = 0; k < n; k++) begin
          @(posedge clk);
          out_stall <= 1;
        end
      end else begin
        for (k = 0; k < n; k++) begin
          @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(kbce_in_t rq);
    int k, gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      for (k = 0; k < gap; k++) begin
        @(posedge clk);
        in_valid <= 0;
      end
    end
    @(posedge clk);
    in_valid <= 1;
    in_data <= rq;
    do @(posedge clk); while (in_stall);
    in_valid <= 0;
    case (rq.req_type)
      REQ_ADD: n_add++;
      REQ_REMOVE: n_rem++;
      default: n_eval++;
    endcase
  endtask

  function automatic kbce_in_t make_req(logic [1:0] op, int t, int v, int o, int i, int r);
    kbce_in_t q;
    q.req_type = op;
    q.time_point = t[15:0];
    q.key_value = v[15:0];
    q.out_ctrl_y = o[15:0];
    q.in_ctrl_y = i[15:0];
    q.remove_index = r[3:0];
    return q;
  endfunction

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Time drawn mostly from a small pool so that matches and duplicates happen
  function automatic int pick_time();
    if ($urandom_range(0, 2) == 0) return rnd16();
    return pool_t[$urandom_range(0, 7)];
  endfunction

  initial begin
    int k, w;
    kbce_in_t q;
    sb = new();
    calm = 0;
    idle_cycles = 0;
    n_add = 0; n_rem = 0; n_eval = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // Directed: empty table, extremes, reserved type, fill, duplicates, removes
    send_request(make_req(REQ_EVAL, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_REMOVE, 0, 0, 0, 0, 0));
    send_request(make_req(2'd3, -1, -1, -1, -1, 15));
    send_request(make_req(REQ_ADD, -32768, 32767, -32768, 32767, 0));
    send_request(make_req(REQ_EVAL, -32768, 0, 0, 0, 0));
    send_request(make_req(REQ_EVAL, -32767, 0, 0, 0, 0));
    send_request(make_req(REQ_ADD, 32767, -32768, 32767, -32768, 15));
    send_request(make_req(REQ_EVAL, 0, 0, 0, 0, 0));
    send_request(make_req(REQ_EVAL, 32766, 0, 0, 0, 0));
    send_request(make_req(REQ_ADD, 32767, 1, 1, 1, 0));
    for (k = 0; k < 15; k++)
      send_request(make_req(REQ_ADD, 100 * k - 700, rnd16(), rnd16(), rnd16(), 0));
    send_request(make_req(REQ_EVAL, 50, 0, 0, 0, 0));
    send_request(make_req(REQ_REMOVE, 0, 0, 0, 0, 15));
    send_request(make_req(REQ_REMOVE, 0, 0, 0, 0, 15));
    send_request(make_req(REQ_REMOVE, 0, 0, 0, 0, 0));

    // Random: short table lifetimes with random content
    for (w = 0; w < 1000; w++) begin
      if (w == 850) calm = 1;
      if (w % 40 == 0)
        for (k = 0; k < 8; k++) pool_t[k] = rnd16();
      case ($urandom_range(0, 9))
        0, 1, 2:
          q = make_req(REQ_ADD, pick_time(), rnd16(), rnd16(), rnd16(), $urandom_range(0, 15));
        3, 4:
          q = make_req(REQ_REMOVE, rnd16(), rnd16(), rnd16(), rnd16(),
                       $urandom_range(0, 15));
        9:
          q = make_req(2'd3, rnd16(), rnd16(), rnd16(), rnd16(), $urandom_range(0, 15));
        default:
          q = make_req(REQ_EVAL, pick_time(), rnd16(), rnd16(), rnd16(),
                       $urandom_range(0, 15));
      endcase
      send_request(q);
    end

    // Drain outstanding responses, then allow the tail latency
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("covered %0d adds, %0d removes, %0d evaluates or reserved requests",
             n_add, n_rem, n_eval);
    $display("responses checked: %0d, mismatches: %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
